// ===== src/ppwd_pkg.sv =====
`timescale 1ns / 1ps
// Package for the pulse pair width decoder: field widths, symbol constants
// and the result struct passed from the pairing logic to the top level.
// No dependencies.
package ppwd_pkg;

    localparam int TimeW    = 16;
    localparam int SymW     = 5;
    localparam int WordW    = 2 * SymW;

    // Symbol = floor(width / 15) - 15, valid while 0..31.
    // Lowest in-range width is 15 * 15, first too-long width is 47 * 15.
    localparam logic [TimeW-1:0] WidthLo = 16'd225;
    localparam logic [TimeW-1:0] WidthHi = 16'd705;

    // Offset width (0..479) times 2185 / 2^15 equals floor(offset / 15).
    localparam int OffW     = 9;
    localparam int RecipW   = 12;
    localparam int ProdW    = OffW + RecipW;
    localparam int RecipSh  = 15;
    localparam logic [RecipW-1:0] Recip15 = 12'd2185;

    localparam logic [SymW-1:0] SymMax = 5'd31;

    typedef struct packed {
        logic             valid;
        logic [WordW-1:0] word;
        logic             err;
    } t_result;

endpackage

// ===== src/ppwd_symbol.sv =====
`timescale 1ns / 1ps
// Width to symbol conversion: constant divide by 15, offset and saturate.
// Depends on ppwd_pkg.
module ppwd_symbol (
    input  logic [ppwd_pkg::TimeW-1:0] i_width,
    output logic [ppwd_pkg::SymW-1:0]  o_symbol,
    output logic                       o_err
);

    logic                        w_short;
    logic                        w_long;
    logic [ppwd_pkg::TimeW-1:0]  w_diff;
    logic [ppwd_pkg::OffW-1:0]   w_off;
    logic [ppwd_pkg::ProdW-1:0]  w_prod;

    assign w_short = i_width < ppwd_pkg::WidthLo;
    assign w_long  = i_width >= ppwd_pkg::WidthHi;
    assign w_diff  = i_width - ppwd_pkg::WidthLo;
    assign w_off   = w_diff[ppwd_pkg::OffW-1:0];
    // reciprocal multiply, exact for offsets below 480
    assign w_prod  = ppwd_pkg::ProdW'(w_off) * ppwd_pkg::ProdW'(ppwd_pkg::Recip15);

    always_comb begin
        if (w_short) begin
            o_symbol = '0;
        end else if (w_long) begin
            o_symbol = ppwd_pkg::SymMax;
        end else begin
            o_symbol = w_prod[ppwd_pkg::RecipSh +: ppwd_pkg::SymW];
        end
    end

    assign o_err = w_short | w_long;

endmodule

// ===== src/ppwd_pair.sv =====
`timescale 1ns / 1ps
// Edge and pair tracking: rise capture, width measure, first-symbol hold
// and word packing. Depends on ppwd_pkg and ppwd_symbol.
module ppwd_pair (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [ppwd_pkg::TimeW-1:0] i_edge_time,
    output ppwd_pkg::t_result          o_res
);

    logic                        r_awaiting_fall, n_awaiting_fall;
    logic                        r_on_second, n_on_second;
    logic [ppwd_pkg::TimeW-1:0]  r_rise_time, n_rise_time;
    logic [ppwd_pkg::SymW-1:0]   r_held_symbol, n_held_symbol;
    logic                        r_held_error, n_held_error;

    logic [ppwd_pkg::TimeW-1:0]  w_width;
    logic [ppwd_pkg::SymW-1:0]   w_sym;
    logic                        w_err;

    // modular difference handles a timer wrap between the edges
    assign w_width = i_edge_time - r_rise_time;

    ppwd_symbol u_symbol (
        .i_width  (w_width),
        .o_symbol (w_sym),
        .o_err    (w_err)
    );

    always_comb begin
        n_awaiting_fall = r_awaiting_fall;
        n_on_second     = r_on_second;
        n_rise_time     = r_rise_time;
        n_held_symbol   = r_held_symbol;
        n_held_error    = r_held_error;
        o_res.valid     = 1'b0;
        o_res.word      = {r_held_symbol, w_sym};
        o_res.err       = r_held_error | w_err;
        if (i_adv) begin
            n_awaiting_fall = ~r_awaiting_fall;
            if (!r_awaiting_fall) begin
                n_rise_time = i_edge_time;
            end else begin
                n_on_second = ~r_on_second;
                if (!r_on_second) begin
                    n_held_symbol = w_sym;
                    n_held_error  = w_err;
                end else begin
                    o_res.valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting_fall <= 1'b0;
            r_on_second     <= 1'b0;
            r_rise_time     <= '0;
            r_held_symbol   <= '0;
            r_held_error    <= 1'b0;
        end else begin
            r_awaiting_fall <= n_awaiting_fall;
            r_on_second     <= n_on_second;
            r_rise_time     <= n_rise_time;
            r_held_symbol   <= n_held_symbol;
            r_held_error    <= n_held_error;
        end
    end

`ifndef SYNTHESIS
    a_res_on_second_fall: assert property (@(posedge i_clk)
        o_res.valid |-> r_awaiting_fall && r_on_second)
        else $error("result outside second falling edge");

    a_edge_toggles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv |=> r_awaiting_fall != $past(r_awaiting_fall))
        else $error("edge phase did not toggle");

    a_reset_phase: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_awaiting_fall && !r_on_second)
        else $error("phase not cleared by reset");
`endif

endmodule

// ===== src/pulse_pair_width_decoder.sv =====
`timescale 1ns / 1ps
// Pulse pair width decoder top level: input register stage, pairing logic,
// output register. Depends on ppwd_pkg and ppwd_pair.
//
// Path: the item of a pair's second falling edge is held in the input
//   register; its result is then registered in the output register.
// Throughput: one item per cycle while the output is not stalled; the output
//   register frees in the cycle its word is taken, so the stage ahead moves.
// Reset: synchronous active-low i_rst_n clears both valid flags and the
//   edge/pair phase; the next item is taken as a rising edge of a first pulse.
module pulse_pair_width_decoder (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [ppwd_pkg::TimeW-1:0] i_edge_time,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [ppwd_pkg::WordW-1:0] o_decoded_word,
    output logic                       o_range_error
);

    // input register stage
    logic                        r_s1_valid, n_s1_valid;
    logic [ppwd_pkg::TimeW-1:0]  r_s1_time;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [ppwd_pkg::WordW-1:0]  r_out_word;
    logic                        r_out_err;

    logic                        w_out_free;
    logic                        w_s1_adv;
    logic                        w_accept;
    ppwd_pkg::t_result           w_res;

    // Output register can load when empty or when its item leaves this cycle.
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_s1_adv   = r_s1_valid & w_out_free;
    // Hold the input side only while the stage is full and cannot advance.
    assign o_in_stall = r_s1_valid & ~w_out_free;
    assign w_accept   = i_in_valid & ~o_in_stall;

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (w_accept) begin
            n_s1_valid = 1'b1;
        end else if (w_s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    // capture payload on accept only
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_time <= i_edge_time;
        end
    end

    ppwd_pair u_pair (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (w_s1_adv),
        .i_edge_time (r_s1_time),
        .o_res       (w_res)
    );

    // Rising edges and first pulses give no result: the register then empties.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_out_free) begin
            n_out_valid = w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.valid) begin
            r_out_word <= w_res.word;
            r_out_err  <= w_res.err;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_decoded_word = r_out_word;
    assign o_range_error  = r_out_err;

`ifndef SYNTHESIS
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> w_out_free)
        else $error("result produced while output register blocked");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_valid && r_out_valid)
        else $error("input stalled with free room downstream");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for pulse_pair_width_decoder: drives edge capture
// times, predicts each packed symbol word and checks it. Depends on ppwd_pkg.
module testbench;

    localparam int TimeW = ppwd_pkg::TimeW;
    localparam int SymW  = ppwd_pkg::SymW;
    localparam int WordW = ppwd_pkg::WordW;

    // Symbol mapping: floor(width / 15) - 15, clamped to 0..31.
    localparam int unsigned SymDivisor = 15;
    localparam int unsigned SymOffset  = 15;

    // Predictor and result check for the decoder, kept in one object.
    class pulse_word_scoreboard;
        typedef struct {
            logic [WordW-1:0] word;
            logic             err;
        } word_t;

        word_t words_due[$];

        // Own copy of the edge and pair phase.
        bit               expect_fall;
        bit               second_of_pair;
        logic [TimeW-1:0] rise_stamp;
        logic [SymW-1:0]  first_sym;
        bit               first_err;

        int edges_taken;
        int words_checked;
        int flagged_words;
        int mismatches;

        function automatic logic [SymW-1:0] width_symbol(logic [TimeW-1:0] width,
                                                         output bit clamped);
            int unsigned quot;
            quot    = int'(width) / SymDivisor;
            clamped = 1'b1;
            if (quot < SymOffset) return '0;
            quot -= SymOffset;
            if (quot > int'(ppwd_pkg::SymMax)) return ppwd_pkg::SymMax;
            clamped = 1'b0;
            return quot[SymW-1:0];
        endfunction

        // Advance the predicted state for one accepted edge item.
        function void note_edge(logic [TimeW-1:0] stamp);
            logic [TimeW-1:0] width;
            logic [SymW-1:0]  sym;
            bit               clamped;
            word_t            due;
            edges_taken++;
            if (!expect_fall) begin
                rise_stamp  = stamp;
                expect_fall = 1'b1;
                return;
            end
            expect_fall = 1'b0;
            width = stamp - rise_stamp;
            sym   = width_symbol(width, clamped);
            if (!second_of_pair) begin
                first_sym      = sym;
                first_err      = clamped;
                second_of_pair = 1'b1;
                return;
            end
            second_of_pair = 1'b0;
            due.word = {first_sym, sym};
            due.err  = first_err | clamped;
            words_due.push_back(due);
        endfunction

        function void report(string what, logic [WordW-1:0] exp_word, logic exp_err,
                             logic [WordW-1:0] word, logic err);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s: expected word %03h err %0b, got word %03h err %0b",
                         $realtime, what, exp_word, exp_err, word, err);
        endfunction

        // Compare one accepted result with the oldest expected word.
        function void check_word(logic [WordW-1:0] word, logic err);
            word_t due;
            words_checked++;
            if (err === 1'b1) flagged_words++;
            if (words_due.size() == 0) begin
                report("unexpected word", 'x, 1'bx, word, err);
                return;
            end
            due = words_due.pop_front();
            if (due.word !== word || due.err !== err)
                report("word mismatch", due.word, due.err, word, err);
        endfunction
    endclass

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             in_valid    = 1'b0;
    logic [TimeW-1:0] edge_time   = '0;
    logic             out_stall   = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    logic [WordW-1:0] o_decoded_word;
    logic             o_range_error;

    // Set during burst stretches: both sides then run with no idle cycles.
    bit no_idle = 1'b0;

    pulse_word_scoreboard sb = new;

    pulse_pair_width_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_edge_time    (edge_time),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_decoded_word (o_decoded_word),
        .o_range_error  (o_range_error)
    );

    always #5 i_clk = ~i_clk;

    function automatic int idle_cycles();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    // Present one edge capture time; return once the block has taken it.
    // Valid stays high between back-to-back items so it is never toggled
    // within one time step.
    task automatic send_edge(input logic [TimeW-1:0] stamp);
        int gap;
        gap = idle_cycles();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        edge_time <= stamp;
        // Reads right after the edge see pre-edge values, so this is the
        // handshake outcome at that edge.
        do @(posedge i_clk); while (o_in_stall);
        sb.note_edge(stamp);
    endtask

    // One pulse: rising edge at rise, falling edge width counts later,
    // wrapping through the 16-bit timer where needed.
    task automatic send_pulse(input logic [TimeW-1:0] rise, input logic [TimeW-1:0] width);
        logic [TimeW-1:0] fall;
        fall = rise + width;
        send_edge(rise);
        send_edge(fall);
    endtask

    // Draw a pulse width: mostly inside the symbol range, the rest short,
    // long, near the clamp boundaries, or anywhere in the timer range.
    function automatic logic [TimeW-1:0] random_width();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return 16'($urandom_range(225, 704));
        if (pick < 78) return 16'($urandom_range(0, 224));
        if (pick < 86) return 16'($urandom_range(705, 2000));
        if (pick < 94) return $urandom_range(0, 1) ? 16'($urandom_range(218, 232))
                                                    : 16'($urandom_range(698, 712));
        return 16'($urandom_range(0, 65535));
    endfunction

    // Result side: hold stall for a drawn number of cycles, then drop it and
    // wait for the next word to be taken.
    initial begin : result_sink
        int hold;
        @(posedge i_clk iff i_rst_n);
        forever begin
            hold = idle_cycles();
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Check every word taken at an edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall)
            sb.check_word(o_decoded_word, o_range_error);
    end

    initial begin : watchdog
        #5_000_000;
        $display("Timeout with %0d words still expected", sb.words_due.size());
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        int drain;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero width, both clamp boundaries from each side, a
        // full-range width, timer wraps between edges, edge times at 0 and
        // all-ones, and range errors on the first, second and both pulses.
        send_pulse(16'h0000, 16'd0);
        send_pulse(16'hffff, 16'd224);
        send_pulse(16'h1234, 16'd225);
        send_pulse(16'h0064, 16'd239);
        send_pulse(16'hff00, 16'd704);
        send_pulse(16'hffff, 16'd705);
        send_pulse(16'h0005, 16'd719);
        send_pulse(16'hfe00, 16'd720);
        send_pulse(16'h0000, 16'hffff);
        send_pulse(16'haaaa, 16'd480);
        send_pulse(16'h5555, 16'd300);
        send_pulse(16'hfff8, 16'd465);

        // Random pulses in segments; some segments run with no idling.
        for (int seg = 0; seg < 8; seg++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            for (int p = 0; p < 50; p++)
                send_pulse(16'($urandom_range(0, 65535)), random_width());
        end
        no_idle = 1'b0;
        in_valid <= 1'b0;

        // Drain: wait for every expected word, then keep watching for strays.
        while (sb.words_due.size() != 0) @(posedge i_clk);
        for (drain = 0; drain < 10; drain++) @(posedge i_clk);

        $display("Covered %0d edge items, %0d words checked, %0d with range error flagged",
                 sb.edges_taken, sb.words_checked, sb.flagged_words);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
